// ===== rtl/core/scfl_pkg.sv =====
`default_nettype none

package scfl_pkg;

    localparam int ADDR_W   = 18;
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 3;
    localparam int WORD_W   = 32;
    localparam int HCLS_W   = 16;
    localparam int WRD_W    = ADDR_W - 2;

    localparam logic [7:0] SMALL_ID = 8'h22;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NULL      = 3'd1,
        ST_OOM       = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_INVALID   = 3'd4,
        ST_BAD_CLASS = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_POP,
        RES_BUMP
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     head_rd;
        logic     mod_head;
        logic     mod_step;
        logic     arena_rd;
        logic     rd_hdr;
        logic     pop_commit;
        logic     hdr_clear;
        logic     push_commit;
        logic     bump;
        logic     set_exh;
        logic     res_load;
        t_res_sel res_sel;
        logic     publish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic size_zero;
        logic size_large;
        logic addr_null;
        logic head_nz;
        logic mod_done;
        logic no_room;
        logic no_fit;
        logic last_page;
        logic id_ok;
        logic cls_bad;
    } t_dp_stat;

    // Restoring steps needed to reduce a WRD_W-bit word index modulo aw.
    function automatic int mod_steps(input int aw);
        int s;
        s = 0;
        while ((aw << s) < (1 << WRD_W)) begin
            s = s + 1;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/scfl_req_if.sv =====
`default_nettype none

interface scfl_req_if;
    import scfl_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] block_addr;

    modport source (output valid, command, req_size, block_addr, input ready);
    modport sink   (input valid, command, req_size, block_addr, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/scfl_rsp_if.sv =====
`default_nettype none

interface scfl_rsp_if;
    import scfl_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   result_addr;
    logic [STATUS_W-1:0] status;

    modport source (output valid, result_addr, status, input ready);
    modport sink   (input valid, result_addr, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/scfl_dp.sv =====
`default_nettype none

module scfl_dp #(
    parameter int PAGE_BYTES        = 65536,
    parameter int NUM_PAGES         = 4,
    parameter int SMALL_LIMIT_BYTES = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire scfl_pkg::t_dp_cmd         i_cmd,
    output scfl_pkg::t_dp_stat             o_stat,
    input  wire logic                      i_command,
    input  wire logic [scfl_pkg::SIZE_W-1:0] i_req_size,
    input  wire logic [scfl_pkg::ADDR_W-1:0] i_block_addr,
    output logic [scfl_pkg::ADDR_W-1:0]    o_result_addr
);
    import scfl_pkg::*;

    localparam int NC        = (SMALL_LIMIT_BYTES + 3) / 4;
    localparam int CLS_W     = $clog2(NC + 1);
    localparam int AW        = (NUM_PAGES * PAGE_BYTES + 3) / 4;
    localparam int MW        = $clog2(AW);
    localparam int HB_W      = $clog2(NUM_PAGES * PAGE_BYTES);
    localparam int OFF_W     = $clog2(PAGE_BYTES + 1);
    localparam int NEED_W    = CLS_W + 3;
    localparam int SUM_W     = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 1;
    localparam int HP_W      = ((HB_W > OFF_W) ? HB_W : OFF_W) + 1;
    localparam int PG_W      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int MOD_STEPS = mod_steps(AW);

    // arena and free-list heads
    logic [WORD_W-1:0] r_arena [0:AW-1];
    logic [ADDR_W-1:0] r_heads [0:NC];
    logic [NC:0]       r_hval;

    logic              r_cmd;
    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_addr;
    logic [WRD_W-1:0]  r_wrd;
    logic [CLS_W-1:0]  r_fcls;
    logic [ADDR_W-1:0] r_res;
    logic [ADDR_W-1:0] r_o_addr;
    logic [WORD_W-1:0] r_ard;
    logic [ADDR_W-1:0] r_hrd;
    logic              r_hrv;
    logic [PG_W-1:0]   r_page;
    logic [HB_W-1:0]   r_base;
    logic [OFF_W-1:0]  r_off;
    logic              r_exh;

    logic [SIZE_W:0]   w_sz3;
    logic [CLS_W-1:0]  w_cls;
    logic [NEED_W-1:0] w_need;
    logic              w_no_fit;
    logic [HP_W-1:0]   w_h;
    logic [ADDR_W-1:0] w_hv;
    logic [MW-1:0]     w_word_idx;
    logic [MW-1:0]     w_hdr_idx;
    logic [WRD_W-1:0]  w_step;
    logic              w_mod_done;
    logic [CLS_W-1:0]  w_hcls;
    logic [CLS_W-1:0]  w_head_ra;
    logic [CLS_W-1:0]  w_head_wa;
    logic [ADDR_W-1:0] w_head_wd;
    logic              w_head_we;
    logic [3:0]        w_ar_we;
    logic [MW-1:0]     w_ar_wa;
    logic [MW-1:0]     w_ar_ra;
    logic [WORD_W-1:0] w_ar_wd;
    logic [ADDR_W-1:0] n_res;

    assign w_sz3     = {1'b0, r_size} + (SIZE_W + 1)'(3);
    assign w_cls     = CLS_W'(w_sz3 >> 2);
    assign w_need    = (NEED_W'(w_cls) + NEED_W'(1)) << 2;
    assign w_no_fit  = (SUM_W'(r_off) + SUM_W'(w_need)) > SUM_W'(PAGE_BYTES);
    assign w_h       = w_no_fit ? (HP_W'(r_base) + HP_W'(PAGE_BYTES))
                                : (HP_W'(r_base) + HP_W'(r_off));
    assign w_hv      = r_hrv ? r_hrd : '0;
    assign w_hcls    = CLS_W'(r_ard[HCLS_W-1:0]);

    // r_wrd holds the word index already reduced modulo the arena size
    assign w_word_idx = MW'(r_wrd);
    assign w_hdr_idx  = (r_wrd == '0) ? MW'(AW - 1) : MW'(r_wrd - 1'b1);

    generate
        if (MOD_STEPS > 0) begin : g_red
            localparam int              MC_W     = $clog2(MOD_STEPS + 1);
            localparam logic [WRD_W-1:0] DIV_INIT = WRD_W'(AW << (MOD_STEPS - 1));
            logic [MC_W-1:0]  r_mcnt;
            logic [WRD_W-1:0] r_div;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mcnt <= '0;
                end else if (i_cmd.load || i_cmd.mod_head) begin
                    r_mcnt <= MC_W'(MOD_STEPS);
                end else if (i_cmd.mod_step) begin
                    r_mcnt <= r_mcnt - 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.load || i_cmd.mod_head) begin
                    r_div <= DIV_INIT;
                end else if (i_cmd.mod_step) begin
                    r_div <= r_div >> 1;
                end
            end

            assign w_step     = (r_wrd >= r_div) ? (r_wrd - r_div) : r_wrd;
            assign w_mod_done = (r_mcnt == '0);
        end else begin : g_nored
            assign w_step     = r_wrd;
            assign w_mod_done = 1'b1;
        end
    endgenerate

    // arena write and read port selection
    always_comb begin
        w_ar_we = 4'b0000;
        w_ar_wa = w_hdr_idx;
        w_ar_wd = '0;
        if (i_cmd.pop_commit) begin
            w_ar_we = 4'b1000;
            w_ar_wd = {SMALL_ID, 24'h000000};
        end else if (i_cmd.hdr_clear) begin
            w_ar_we = 4'b1000;
        end else if (i_cmd.push_commit) begin
            w_ar_we = 4'b1111;
            w_ar_wa = w_word_idx;
            w_ar_wd = WORD_W'(w_hv);
        end else if (i_cmd.bump) begin
            w_ar_we = 4'b1111;
            w_ar_wa = MW'(w_h >> 2);
            w_ar_wd = {SMALL_ID, 8'h00, HCLS_W'(w_cls)};
        end
    end

    assign w_ar_ra = i_cmd.rd_hdr ? w_hdr_idx : w_word_idx;

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 4; b++) begin
            if (w_ar_we[b]) begin
                r_arena[w_ar_wa][8*b +: 8] <= w_ar_wd[8*b +: 8];
            end
        end
        if (i_cmd.arena_rd) begin
            r_ard <= r_arena[w_ar_ra];
        end
    end

    // free-list heads
    assign w_head_ra = r_cmd ? w_hcls : w_cls;
    assign w_head_wa = r_cmd ? r_fcls : w_cls;
    assign w_head_wd = i_cmd.push_commit ? r_addr : r_ard[ADDR_W-1:0];
    assign w_head_we = i_cmd.pop_commit || i_cmd.push_commit;

    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            r_heads[w_head_wa] <= w_head_wd;
        end
        if (i_cmd.head_rd) begin
            r_hrd <= r_heads[w_head_ra];
            r_hrv <= r_hval[w_head_ra];
        end
    end

    always_comb begin
        case (i_cmd.res_sel)
            RES_POP:  n_res = w_hv;
            RES_BUMP: n_res = ADDR_W'(w_h + HP_W'(4));
            default:  n_res = '0;
        endcase
    end

    // command latch, word index reduction, result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_size <= i_req_size;
            r_addr <= i_block_addr;
            r_wrd  <= i_block_addr[ADDR_W-1:2];
        end else if (i_cmd.mod_head) begin
            r_wrd  <= w_hv[ADDR_W-1:2];
        end else if (i_cmd.mod_step) begin
            r_wrd  <= w_step;
        end
        if (i_cmd.head_rd && r_cmd) begin
            r_fcls <= w_hcls;
        end
        if (i_cmd.res_load) begin
            r_res <= n_res;
        end
        if (i_cmd.publish) begin
            r_o_addr <= r_res;
        end
    end

    // page cursor and list valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= '0;
            r_base <= '0;
            r_off  <= '0;
            r_exh  <= 1'b0;
            r_hval <= '0;
        end else begin
            if (i_cmd.set_exh) begin
                r_exh <= 1'b1;
            end
            if (i_cmd.bump) begin
                if (w_no_fit) begin
                    r_page <= r_page + 1'b1;
                    r_base <= HB_W'(w_h);
                    r_off  <= OFF_W'(w_need);
                end else begin
                    r_off  <= r_off + OFF_W'(w_need);
                end
            end
            if (w_head_we) begin
                r_hval[w_head_wa] <= 1'b1;
            end
        end
    end

    assign o_stat.is_free    = (r_cmd == CMD_FREE);
    assign o_stat.size_zero  = (r_size == '0);
    assign o_stat.size_large = (r_size >= SIZE_W'(SMALL_LIMIT_BYTES));
    assign o_stat.addr_null  = (r_addr == '0);
    assign o_stat.head_nz    = (w_hv != '0);
    assign o_stat.mod_done   = w_mod_done;
    assign o_stat.no_room    = r_exh || (SUM_W'(w_need) > SUM_W'(PAGE_BYTES));
    assign o_stat.no_fit     = w_no_fit;
    assign o_stat.last_page  = (r_page == PG_W'(NUM_PAGES - 1));
    assign o_stat.id_ok      = (r_ard[WORD_W-1:WORD_W-8] == SMALL_ID);
    assign o_stat.cls_bad    = (r_ard[HCLS_W-1:0] > HCLS_W'(NC));

    assign o_result_addr = r_o_addr;

endmodule

`default_nettype wire

// ===== rtl/core/scfl_ctrl.sv =====
`default_nettype none

module scfl_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    output logic                    o_req_ready,
    output logic                    o_rsp_valid,
    input  wire logic               i_rsp_ready,
    output scfl_pkg::t_status       o_status,
    input  wire scfl_pkg::t_dp_stat i_stat,
    output scfl_pkg::t_dp_cmd       o_cmd
);
    import scfl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_HEAD,
        S_MOD,
        S_PLINK,
        S_FHDR,
        S_FPUSH,
        S_REPLY
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    t_status r_o_status;
    logic    r_o_valid, n_o_valid;

    assign o_req_ready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        o_cmd         = '0;
        o_cmd.res_sel = RES_ZERO;
        n_state       = r_state;
        n_status      = r_status;
        n_o_valid     = r_o_valid && !i_rsp_ready;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (!i_stat.is_free) begin
                    if (i_stat.size_zero) begin
                        o_cmd.res_load = 1'b1;
                        n_status       = ST_NULL;
                        n_state        = S_REPLY;
                    end else if (i_stat.size_large) begin
                        o_cmd.res_load = 1'b1;
                        n_status       = ST_TOO_LARGE;
                        n_state        = S_REPLY;
                    end else begin
                        o_cmd.head_rd = 1'b1;
                        n_state       = S_HEAD;
                    end
                end else if (i_stat.addr_null) begin
                    o_cmd.res_load = 1'b1;
                    n_status       = ST_NULL;
                    n_state        = S_REPLY;
                end else begin
                    n_state = S_MOD;
                end
            end
            S_HEAD: begin
                if (i_stat.head_nz) begin
                    o_cmd.mod_head = 1'b1;
                    n_state        = S_MOD;
                end else if (i_stat.no_room) begin
                    o_cmd.res_load = 1'b1;
                    n_status       = ST_OOM;
                    n_state        = S_REPLY;
                end else if (i_stat.no_fit && i_stat.last_page) begin
                    o_cmd.set_exh  = 1'b1;
                    o_cmd.res_load = 1'b1;
                    n_status       = ST_OOM;
                    n_state        = S_REPLY;
                end else begin
                    o_cmd.bump     = 1'b1;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_BUMP;
                    n_status       = ST_OK;
                    n_state        = S_REPLY;
                end
            end
            S_MOD: begin
                if (!i_stat.mod_done) begin
                    o_cmd.mod_step = 1'b1;
                end else begin
                    o_cmd.arena_rd = 1'b1;
                    o_cmd.rd_hdr   = i_stat.is_free;
                    n_state        = i_stat.is_free ? S_FHDR : S_PLINK;
                end
            end
            S_PLINK: begin
                o_cmd.pop_commit = 1'b1;
                o_cmd.res_load   = 1'b1;
                o_cmd.res_sel    = RES_POP;
                n_status         = ST_OK;
                n_state          = S_REPLY;
            end
            S_FHDR: begin
                if (!i_stat.id_ok) begin
                    o_cmd.res_load = 1'b1;
                    n_status       = ST_INVALID;
                    n_state        = S_REPLY;
                end else begin
                    o_cmd.hdr_clear = 1'b1;
                    if (i_stat.cls_bad) begin
                        o_cmd.res_load = 1'b1;
                        n_status       = ST_BAD_CLASS;
                        n_state        = S_REPLY;
                    end else begin
                        o_cmd.head_rd = 1'b1;
                        n_state       = S_FPUSH;
                    end
                end
            end
            S_FPUSH: begin
                o_cmd.push_commit = 1'b1;
                o_cmd.res_load    = 1'b1;
                n_status          = ST_OK;
                n_state           = S_REPLY;
            end
            S_REPLY: begin
                if (!r_o_valid || i_rsp_ready) begin
                    o_cmd.publish = 1'b1;
                    n_o_valid     = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // r_status stages the next beat's status; r_o_status holds the beat on the port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_status   <= ST_OK;
            r_o_status <= ST_OK;
            r_o_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_o_valid <= n_o_valid;
            if (o_cmd.publish) begin
                r_o_status <= r_status;
            end
        end
    end

    assign o_rsp_valid = r_o_valid;
    assign o_status    = r_o_status;

endmodule

`default_nettype wire

// ===== rtl/core/size_class_free_list_allocator.sv =====
// Small-block heap allocator with per-size-class free lists over a page arena.
// Request channel i_req: command (0 allocate req_size bytes, 1 free block_addr).
// Response channel o_rsp: result_addr and status, one beat per request beat.
// Both channels move a beat on a rising edge with valid and ready high.
// A request is taken only when the sequencer is idle; one request is worked
// on at a time and the next may enter while the previous response still waits.
// Sequencer steps from request beat to response, with an idle response slot:
//   null / too large:      decode, reply
//   allocate by bump:      decode, head read, reply
//   allocate by list pop:  decode, head read, reduction and link read, pop, reply
//   free:                  decode, reduction and header read, header check, push, reply
//   (no push when the header is invalid or bad class)
// The request port reopens as soon as the response goes valid. Pops and frees
// also walk the word-index reduction, which has no steps when the arena spans
// the whole 18-bit address space (the default). The arena read is registered:
// the header or link word is read first and written back in a later step.
// Reset empties every free list, rewinds to page 0 and clears the response
// slot; no clearing pass runs, the block takes requests right after reset.
// A stalled receiver holds the response beat stable; the sequencer waits in
// its reply step until the slot frees, without touching any other state.
`default_nettype none

module size_class_free_list_allocator #(
    parameter int PAGE_BYTES        = 65536,
    parameter int NUM_PAGES         = 4,
    parameter int SMALL_LIMIT_BYTES = 256
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    scfl_req_if.sink i_req,
    scfl_rsp_if.source o_rsp
);
    import scfl_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_status  w_status;
    logic     w_req_ready;
    logic     w_rsp_valid;

    // sequencer: decides each step and when the response beat goes out
    scfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_status    (w_status),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: arena memory, list heads, page cursor, result register
    scfl_dp #(
        .PAGE_BYTES        (PAGE_BYTES),
        .NUM_PAGES         (NUM_PAGES),
        .SMALL_LIMIT_BYTES (SMALL_LIMIT_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_command     (i_req.command),
        .i_req_size    (i_req.req_size),
        .i_block_addr  (i_req.block_addr),
        .o_result_addr (o_rsp.result_addr)
    );

    assign i_req.ready  = w_req_ready;
    assign o_rsp.valid  = w_rsp_valid;
    assign o_rsp.status = STATUS_W'(w_status);

endmodule

`default_nettype wire

// ===== rtl/core/scfl_chk.sv =====
`default_nettype none

module scfl_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_req_valid,
    input wire logic                          i_req_ready,
    input wire logic                          i_rsp_valid,
    input wire logic                          i_rsp_ready,
    input wire logic [scfl_pkg::ADDR_W-1:0]   i_rsp_result_addr,
    input wire logic [scfl_pkg::STATUS_W-1:0] i_rsp_status
);
    import scfl_pkg::*;

    // one request at a time: the port closes right after a request beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request port open right after a request beat");

    // every failure and no-op reports a null address
    a_fail_null_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != STATUS_W'(ST_OK))) |-> (i_rsp_result_addr == '0))
        else $error("non-ok response carries an address");

    // reset drops any pending response
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_result_addr) && $stable(i_rsp_status)))
        else $error("stalled response changed");

endmodule

bind size_class_free_list_allocator scfl_chk u_scfl_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_result_addr (o_rsp.result_addr),
    .i_rsp_status      (o_rsp.status)
);

`default_nettype wire

// ===== tb/tb_size_class_free_list_allocator.sv =====
`timescale 1ns / 100ps

module tb_size_class_free_list_allocator;
    import scfl_pkg::*;

    // Arena geometry as built by the default parameters of the block.
    localparam int PAGE_SIZE    = 65536;
    localparam int PAGE_COUNT   = 4;
    localparam int SMALL_LIMIT  = 256;
    localparam int CLASS_COUNT  = (SMALL_LIMIT + 3) / 4;
    localparam int HDR_SIZE     = 4;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_ITEMS  = 180;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        t_status           status;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    scfl_req_if req_if ();
    scfl_rsp_if rsp_if ();

    size_class_free_list_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow heap: arena words written so far, list heads and the bump pointer.
    logic [WORD_W-1:0] arena_img [bit [WRD_W-1:0]];
    logic [ADDR_W-1:0] free_head [0:CLASS_COUNT];
    int unsigned       bump_page;
    int unsigned       bump_offset;
    bit                pages_gone;

    t_reply            pending_replies [$];
    logic [ADDR_W-1:0] live_blocks [$];
    logic [WRD_W-1:0]  bump_headers [$];

    int src_idle_pct;
    int sink_stall_pct;
    int rsp_hold_left;
    int quiet_cycles;
    int mismatch_count;

    always #2 i_clk = ~i_clk;

    // Word holding the first payload word (also the free-list link) of a block.
    function automatic logic [WRD_W-1:0] payload_word(input logic [ADDR_W-1:0] a);
        return a[ADDR_W-1:2];
    endfunction

    // Header word just below the payload; wraps to the last arena word.
    function automatic logic [WRD_W-1:0] header_word(input logic [ADDR_W-1:0] a);
        return a[ADDR_W-1:2] - 1'b1;
    endfunction

    // Compute the reply to one command and advance the shadow heap.
    function automatic t_reply predict_reply(input logic              cmd,
                                             input logic [SIZE_W-1:0] size_b,
                                             input logic [ADDR_W-1:0] addr_b);
        t_reply            r;
        int unsigned       bytes;
        int unsigned       cls;
        int unsigned       need;
        int unsigned       hdr_byte;
        logic [ADDR_W-1:0] head;
        logic [WRD_W-1:0]  hw_idx;
        logic [WORD_W-1:0] hw;

        r.addr   = '0;
        r.status = ST_OK;
        if (cmd == CMD_ALLOC) begin
            if (size_b == '0) begin
                r.status = ST_NULL;
            end else if (size_b >= SMALL_LIMIT) begin
                r.status = ST_TOO_LARGE;
            end else begin
                bytes = (size_b < 4) ? 4 : size_b;
                bytes = (bytes + 3) & ~32'd3;
                cls   = bytes / 4;
                head  = free_head[cls];
                if (head != '0) begin
                    // Pop: follow the link, then tag the header as in use again.
                    free_head[cls]    = arena_img[payload_word(head)][ADDR_W-1:0];
                    hw_idx            = header_word(head);
                    arena_img[hw_idx] = {SMALL_ID, arena_img[hw_idx][23:0]};
                    r.addr            = head;
                end else begin
                    need = bytes + HDR_SIZE;
                    // Step to the next page when this one cannot hold the block.
                    if (!pages_gone && need <= PAGE_SIZE && PAGE_SIZE - bump_offset < need) begin
                        if (bump_page + 1 >= PAGE_COUNT) begin
                            pages_gone = 1'b1;
                        end else begin
                            bump_page++;
                            bump_offset = 0;
                        end
                    end
                    if (pages_gone || need > PAGE_SIZE) begin
                        r.status = ST_OOM;
                    end else begin
                        hdr_byte          = bump_page * PAGE_SIZE + bump_offset;
                        hw_idx            = hdr_byte[ADDR_W-1:2];
                        arena_img[hw_idx] = {SMALL_ID, 8'h00, HCLS_W'(cls)};
                        bump_headers.push_back(hw_idx);
                        bump_offset += need;
                        r.addr       = ADDR_W'(hdr_byte + HDR_SIZE);
                    end
                end
            end
        end else if (addr_b == '0) begin
            r.status = ST_NULL;
        end else begin
            hw_idx = header_word(addr_b);
            hw     = arena_img[hw_idx];
            if (hw[31:24] != SMALL_ID) begin
                r.status = ST_INVALID;
            end else begin
                // Clear the ID first; a bad class still leaves it cleared.
                arena_img[hw_idx] = {8'h00, hw[23:0]};
                cls               = hw[HCLS_W-1:0];
                if (cls > CLASS_COUNT) begin
                    r.status = ST_BAD_CLASS;
                end else begin
                    arena_img[payload_word(addr_b)] = WORD_W'(free_head[cls]);
                    free_head[cls]                  = addr_b;
                end
            end
        end
        return r;
    endfunction

    // Offer one request beat, hold it until taken, then queue its expected reply.
    // Valid stays high after the beat; the next call or a drain decides its fate.
    task automatic send_beat(input logic              cmd,
                             input logic [SIZE_W-1:0] size_b,
                             input logic [ADDR_W-1:0] addr_b,
                             output t_reply           exp);
        int idx [$];

        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.command    <= cmd;
        req_if.req_size   <= size_b;
        req_if.block_addr <= addr_b;
        do @(posedge i_clk); while (!req_if.ready);
        exp = predict_reply(cmd, size_b, addr_b);
        pending_replies.push_back(exp);
        if (exp.status == ST_OK) begin
            if (cmd == CMD_ALLOC) begin
                live_blocks.push_back(exp.addr);
            end else begin
                idx = live_blocks.find_first_index(x) with (x == addr_b);
                if (idx.size() != 0) live_blocks.delete(idx[0]);
            end
        end
    endtask

    // Drop valid and hold the sender until every reply is back.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    // Mostly well-formed traffic: allocate, free live blocks; some foreign
    // addresses, double frees and null frees mixed in.
    task automatic send_random_item();
        t_reply            r;
        int unsigned       pick;
        int unsigned       size_pick;
        logic [SIZE_W-1:0] size_b;
        logic [ADDR_W-1:0] target;
        logic [WRD_W-1:0]  h;

        pick      = $urandom_range(99);
        size_pick = $urandom_range(19);
        if (size_pick == 0)      size_b = '0;
        else if (size_pick < 3)  size_b = SIZE_W'($urandom_range(SMALL_LIMIT, 65535));
        else if (size_pick < 15) size_b = SIZE_W'($urandom_range(1, 64));
        else                     size_b = SIZE_W'($urandom_range(1, SMALL_LIMIT - 1));

        if (pick < 50 || (pick < 86 && live_blocks.size() == 0) ||
            (pick < 96 && bump_headers.size() == 0)) begin
            send_beat(CMD_ALLOC, size_b, ADDR_W'($urandom), r);
        end else if (pick < 86) begin
            target = live_blocks[$urandom_range(live_blocks.size() - 1)];
            send_beat(CMD_FREE, size_b, target, r);
        end else if (pick < 96) begin
            // Aim at or just past a known header, with random low bits.
            h      = bump_headers[$urandom_range(bump_headers.size() - 1)];
            target = {h + WRD_W'($urandom_range(1, 2)), 2'($urandom)};
            if (!arena_img.exists(header_word(target))) target = {h + 1'b1, 2'($urandom)};
            send_beat(CMD_FREE, size_b, target, r);
        end else begin
            send_beat(CMD_FREE, size_b, '0, r);
        end
    endtask

    // Field extremes, null, too-large and invalid replies, pops and foreign frees.
    task automatic test_directed();
        t_reply r_one;
        t_reply r_two;
        t_reply r_big;
        t_reply r_tmp;

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_beat(CMD_ALLOC, 16'd0, '1, r_tmp);           // zero size
        send_beat(CMD_ALLOC, 16'd256, '0, r_tmp);         // smallest too-large size
        send_beat(CMD_ALLOC, '1, '0, r_tmp);              // largest size
        send_beat(CMD_ALLOC, 16'd1, 18'h2AAAA, r_one);    // raised to 4 bytes
        send_beat(CMD_ALLOC, 16'd4, 18'h15555, r_tmp);
        send_beat(CMD_ALLOC, 16'd5, '0, r_two);           // rounded up to class 2
        send_beat(CMD_ALLOC, 16'd255, '1, r_big);         // top class
        send_beat(CMD_FREE, '1, '0, r_tmp);               // null free
        send_beat(CMD_FREE, 16'h5A5A, r_one.addr, r_tmp);
        send_beat(CMD_FREE, '0, r_one.addr, r_tmp);       // double free, ID gone
        send_beat(CMD_ALLOC, 16'd2, '0, r_tmp);           // pop the class-1 block
        send_beat(CMD_FREE, '0, r_two.addr + 18'd2, r_tmp);  // low bits ignored
        send_beat(CMD_ALLOC, 16'd8, '0, r_tmp);           // pop the unaligned address
        send_beat(CMD_FREE, '0, r_tmp.addr, r_tmp);
        send_beat(CMD_FREE, '0, r_two.addr + 18'd4, r_tmp);  // header is a link word
        send_beat(CMD_FREE, '0, r_big.addr + 18'd3, r_tmp);
        send_beat(CMD_ALLOC, 16'd253, '0, r_tmp);         // pop the top-class block
        send_beat(CMD_ALLOC, 16'd254, '0, r_tmp);         // list empty again: bump
        send_beat(CMD_FREE, '0, r_big.addr, r_tmp);
        send_beat(CMD_FREE, '0, r_big.addr, r_tmp);
        wait_drained();
    endtask

    // Random traffic through each idling phase; drain between phases.
    task automatic test_random_phases();
        int src_pct  [4];
        int sink_pct [4];

        src_pct  = '{0, 74, 0, 18};
        sink_pct = '{0, 0, 74, 18};
        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            repeat (PHASE_ITEMS) send_random_item();
            wait_drained();
        end
    endtask

    // Hold the reply side off while requests keep coming, so the input stalls.
    task automatic test_receiver_hold();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        rsp_hold_left  = HOLD_CYCLES;
        repeat (16) send_random_item();
        wait_drained();
    endtask

    // Use up every page, then check that pops still work and bumps fail.
    task automatic test_exhaust_pages();
        t_reply            r;
        logic [ADDR_W-1:0] target;
        int unsigned       cls;

        src_idle_pct   = 18;
        sink_stall_pct = 18;
        while (!pages_gone) begin
            send_beat(CMD_ALLOC, SIZE_W'($urandom_range(193, SMALL_LIMIT - 1)),
                      ADDR_W'($urandom), r);
        end
        repeat (8) begin
            target = live_blocks[$urandom_range(live_blocks.size() - 1)];
            cls    = arena_img[header_word(target)][HCLS_W-1:0];
            send_beat(CMD_FREE, SIZE_W'($urandom), target, r);
            // Smallest size of the class, so the top class stays below the limit.
            send_beat(CMD_ALLOC, SIZE_W'(cls * 4 - 3), ADDR_W'($urandom), r);
            send_beat(CMD_ALLOC, SIZE_W'(cls * 4 - 3), ADDR_W'($urandom), r);
        end
        // An address below 4 takes its header from the last arena word.
        if (arena_img.exists({WRD_W{1'b1}})) begin
            send_beat(CMD_FREE, '0, ADDR_W'($urandom_range(1, 3)), r);
        end
        wait_drained();
    endtask

    // Check each reply beat against the oldest expectation, then drive ready.
    always @(posedge i_clk) begin : reply_check
        t_reply want;

        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_replies.size() == 0) begin
                $error("reply with none expected: result_addr %0h status %0d",
                       rsp_if.result_addr, rsp_if.status);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                if (rsp_if.result_addr !== want.addr) begin
                    $error("result_addr: expected %0h, actual %0h",
                           want.addr, rsp_if.result_addr);
                    mismatch_count++;
                end
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                    mismatch_count++;
                end
            end
        end
        if (rsp_hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_left--;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // End the run when neither channel has moved a beat for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_size_class_free_list_allocator failed");
            $finish;
        end
    end

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.command    = CMD_ALLOC;
        req_if.req_size   = '0;
        req_if.block_addr = '0;
        rsp_if.ready      = 1'b0;
        src_idle_pct      = 0;
        sink_stall_pct    = 0;
        rsp_hold_left     = 0;
        quiet_cycles      = 0;
        mismatch_count    = 0;
        bump_page         = 0;
        bump_offset       = 0;
        pages_gone        = 1'b0;
        foreach (free_head[i]) free_head[i] = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phases();
        test_receiver_hold();
        test_exhaust_pages();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_size_class_free_list_allocator passed");
        end else begin
            $display("tb_size_class_free_list_allocator failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/scfl_pkg.sv
rtl/core/scfl_req_if.sv
rtl/core/scfl_rsp_if.sv
rtl/core/scfl_dp.sv
rtl/core/scfl_ctrl.sv
rtl/core/size_class_free_list_allocator.sv
rtl/core/scfl_chk.sv
tb/tb_size_class_free_list_allocator.sv
